/* rtl/gpc_pkg.sv */
// ----------------------------------------------------------------------------
// gpc_pkg: shared types and constants of the gamepad pose commander
// Register indexes, pose codes, result record and divider handshake.
// ----------------------------------------------------------------------------
`default_nettype none
package gpc_pkg;
  localparam int AXIS_BITS = 16;

  typedef enum logic [1:0] {
    CFG_DEADZONE = 2'd0,
    CFG_FLOOR    = 2'd1,
    CFG_CEILING  = 2'd2,
    CFG_BASE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POSE_MOVE  = 2'd0,
    POSE_SIT   = 2'd1,
    POSE_STAND = 2'd2
  } pose_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BTN, ST_SCALE, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [9:0]  x;
    logic [10:0]        y;
    logic signed [12:0] z;
    logic [15:0]        ms;
    logic [4:0]         speed;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [4:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

  localparam logic [10:0]        NEUTRAL_Y  = 11'd1000;
  localparam logic signed [12:0] STAND_Z    = -13'sd2000;
  localparam logic signed [12:0] SIT_Z      = -13'sd1200;
  localparam logic [15:0]        POSTURE_MS = 16'd1500;
  localparam logic [15:0]        MIN_MS     = 16'd50;
  localparam logic [4:0]         SPEED_UNITY = 5'd10;
endpackage
`default_nettype wire

/* rtl/gamepad_pose_commander_core.sv */
// ----------------------------------------------------------------------------
// gamepad_pose_commander_core: gamepad report to pose command converter
// Applies dead zone and button edges, emits posture and movement commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one report per transfer. tdata = {right_vert, right_horiz,
//           left_vert, left_horiz} from the low bits up, tuser = {button_bits,
//           well_formed}.
//   out_* : up to four commands per report; tlast marks the last one.
//   cfg_* : register writes, accepted in any cycle; write only when idle.
//   A report is handled one at a time: eight button steps, then the three
//   axis products (axes multiplied serially by one small constant
//   multiplier), then the move time from a one-bit-per-cycle divider.
//   Commands go out one per cycle from a result buffer; a stall on out_tready
//   holds the current command and the block waits.
//   Reset restores speed 1.0, enables servo and movement, clears button
//   history and sets registers to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none
module gamepad_pose_commander_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // left_horiz[15:0], left_vert[31:16], right_horiz[47:32], right_vert[63:48]
  input  wire logic [63:0] in_tdata,
  // well_formed[0], button_bits[14:1], pad
  input  wire logic [15:0] in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // foot_x[9:0], foot_y[20:10], foot_z[33:21], move_ms[49:34],
  // speed_now[54:50], pad
  output logic [55:0]      out_tdata,
  // pose_kind[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import gpc_pkg::*;

  state_t state_r, state_nxt;
  logic [14:0] dz_r;
  logic [4:0]  floor_r, ceil_r, speed_r, speed_nxt;
  logic [11:0] base_r;
  logic        motion_r, motion_nxt, servo_r, servo_nxt;
  logic [7:0]  was_r, was_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic [7:0]  down_r, down_nxt;
  logic signed [15:0] lx_r, ly_r, ry_r, lx_nxt, ly_nxt, ry_nxt;
  logic        any_r, any_nxt;
  logic signed [12:0] fx_r, fy_r, fz_r, fx_nxt, fy_nxt, fz_nxt;
  result_t     buf_r [4];
  result_t     wr_data;
  logic        wr_en;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  rd_r, rd_nxt;
  logic        ovalid_r, ovalid_nxt;
  div_req_t    dreq;
  div_rsp_t    drsp;

  gpc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic signed [15:0] dzone(input logic [15:0] raw,
                                               input logic [14:0] lvl);
    logic [15:0] mag;
    mag = raw[15] ? 16'(-raw) : raw;
    return (mag < {1'b0, lvl}) ? 16'sd0 : $signed(raw);
  endfunction

  // round(|q|*k / 2^15) with sign; |q| <= 2^15 so k*mag fits 25 bits.
  function automatic logic signed [12:0] scale(input logic signed [15:0] q,
                                               input logic [8:0] k);
    logic [15:0] mag;
    logic [24:0] p;
    logic [9:0]  r;
    mag = q[15] ? 16'(-q) : 16'(q);
    p = 25'(mag) * 25'(k) + 25'd16384;
    r = p[24:15];
    return q[15] ? -$signed({3'b0, r}) : $signed({3'b0, r});
  endfunction

  logic [4:0] fl_eff, cl_eff, sm1;
  // One bit wider so that a step up from 31 does not wrap to zero.
  logic [5:0] sp1;
  logic signed [12:0] sc;
  logic signed [15:0] ax_sel;
  logic [8:0] k_sel;
  logic [15:0] ms_q;

  assign fl_eff = (floor_r == 5'd0) ? 5'd1 : floor_r;
  assign cl_eff = (ceil_r == 5'd0) ? 5'd1 : ceil_r;
  assign sm1 = speed_r - 5'd1;
  assign sp1 = {1'b0, speed_r} + 6'd1;
  assign ms_q = (drsp.quotient < MIN_MS) ? MIN_MS : drsp.quotient;

  always_comb begin
    case (ax_r)
      2'd0: begin ax_sel = ly_r; k_sel = 9'd300; end
      2'd1: begin ax_sel = lx_r; k_sel = 9'd200; end
      default: begin ax_sel = ry_r; k_sel = 9'd300; end
    endcase
    sc = scale(ax_sel, k_sel);
  end

  always_comb begin
    state_nxt = state_r; speed_nxt = speed_r; motion_nxt = motion_r;
    servo_nxt = servo_r; was_nxt = was_r; step_nxt = step_r; ax_nxt = ax_r;
    down_nxt = down_r; lx_nxt = lx_r; ly_nxt = ly_r; ry_nxt = ry_r;
    any_nxt = any_r; fx_nxt = fx_r; fy_nxt = fy_r; fz_nxt = fz_r;
    cnt_nxt = cnt_r; rd_nxt = rd_r; ovalid_nxt = ovalid_r;
    wr_en = 1'b0;
    wr_data = '{kind: POSE_STAND, x: 10'sd0, y: NEUTRAL_Y, z: STAND_Z,
                ms: POSTURE_MS, speed: speed_r};
    dreq = '{start: 1'b0, dividend: 16'(base_r) * 16'd10,
             divisor: (speed_r == 5'd0) ? 5'd1 : speed_r};
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser[0]) begin
          lx_nxt = dzone(in_tdata[15:0], dz_r);
          ly_nxt = dzone(in_tdata[31:16], dz_r);
          ry_nxt = dzone(in_tdata[63:48], dz_r);
          any_nxt = (dzone(in_tdata[15:0], dz_r) != 0) ||
                    (dzone(in_tdata[31:16], dz_r) != 0) ||
                    (dzone(in_tdata[47:32], dz_r) != 0) ||
                    (dzone(in_tdata[63:48], dz_r) != 0);
          down_nxt = {in_tuser[11:9], in_tuser[5:1]};
          step_nxt = 3'd0; cnt_nxt = 3'd0; rd_nxt = 2'd0;
          state_nxt = ST_BTN;
        end
      end
      ST_BTN: begin
        was_nxt[step_r] = down_r[step_r];
        if (down_r[step_r] && !was_r[step_r]) begin
          case (step_r)
            3'd0: speed_nxt = (sm1 > fl_eff) ? sm1 : fl_eff;
            3'd1: speed_nxt = (sp1 < {1'b0, cl_eff}) ? sp1[4:0] : cl_eff;
            3'd2: begin
              wr_en = 1'b1; wr_data.kind = POSE_SIT; wr_data.z = SIT_Z;
            end
            3'd3: wr_en = 1'b1;
            3'd4: begin
              servo_nxt = !servo_r;
              wr_en = !servo_r;
            end
            3'd5: motion_nxt = 1'b0;
            3'd6: motion_nxt = 1'b1;
            default: speed_nxt = SPEED_UNITY;
          endcase
          if (wr_en) cnt_nxt = cnt_r + 3'd1;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          ax_nxt = 2'd0;
          state_nxt = (motion_r && servo_r && any_r) ? ST_SCALE : ST_EMIT;
          ovalid_nxt = (cnt_nxt != 3'd0);
        end
      end
      ST_SCALE: begin
        ax_nxt = ax_r + 2'd1;
        case (ax_r)
          2'd0: fx_nxt = sc;
          2'd1: fy_nxt = 13'sd1000 + sc;
          default: fz_nxt = STAND_Z + sc;
        endcase
        if (ax_r == 2'd2) begin
          dreq.start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          wr_en = 1'b1;
          wr_data.kind = POSE_MOVE;
          wr_data.x = (fx_r > 13'sd500) ? 10'sd500 :
                      (fx_r < -13'sd500) ? -10'sd500 : fx_r[9:0];
          wr_data.y = (fy_r > 13'sd1500) ? 11'd1500 :
                      (fy_r < 13'sd500) ? 11'd500 : 11'(fy_r);
          wr_data.z = (fz_r > -13'sd1200) ? -13'sd1200 :
                      (fz_r < -13'sd2500) ? -13'sd2500 : fz_r;
          wr_data.ms = ms_q;
          cnt_nxt = cnt_r + 3'd1;
          ovalid_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_tready) begin
          if (3'(rd_r) + 3'd1 == cnt_r) begin
            ovalid_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
          rd_nxt = rd_r + 2'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    lx_r <= lx_nxt; ly_r <= ly_nxt; ry_r <= ry_nxt; down_r <= down_nxt;
    fx_r <= fx_nxt; fy_r <= fy_nxt; fz_r <= fz_nxt; ax_r <= ax_nxt;
    any_r <= any_nxt;
    if (wr_en) buf_r[cnt_r[1:0]] <= wr_data;
    if (!rst_n) begin
      state_r <= ST_IDLE; speed_r <= SPEED_UNITY; motion_r <= 1'b1;
      servo_r <= 1'b1; was_r <= '0; step_r <= '0; cnt_r <= '0; rd_r <= '0;
      ovalid_r <= 1'b0;
      dz_r <= 15'd4915; floor_r <= 5'd1; ceil_r <= 5'd20; base_r <= 12'd1000;
    end else begin
      state_r <= state_nxt; speed_r <= speed_nxt; motion_r <= motion_nxt;
      servo_r <= servo_nxt; was_r <= was_nxt; step_r <= step_nxt;
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; ovalid_r <= ovalid_nxt;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DEADZONE: dz_r <= cfg_data;
          CFG_FLOOR:    floor_r <= cfg_data[4:0];
          CFG_CEILING:  ceil_r <= cfg_data[4:0];
          CFG_BASE:     base_r <= cfg_data[11:0];
        endcase
      end
    end
  end

  result_t cur;
  assign cur = buf_r[rd_r];
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovalid_r && (state_r == ST_EMIT);
  assign out_tdata = {1'b0, cur.speed, cur.ms, cur.z, cur.y, cur.x};
  assign out_tuser = cur.kind;
  assign out_tlast = (3'(rd_r) + 3'd1 == cnt_r);

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("more than four commands");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(rd_r))
    else $error("command dropped under stall");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("report accepted while emitting");
endmodule
`default_nettype wire

/* rtl/gpc_divider.sv */
// ----------------------------------------------------------------------------
// gpc_divider: radix-2 restoring divider
// Divides a 16-bit dividend by a 5-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gpc_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gpc_pkg::div_req_t req,
  output gpc_pkg::div_rsp_t      rsp
);
  import gpc_pkg::*;

  logic [15:0] q_r, q_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [4:0]  d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]  trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[4:0], q_r[15]};
    if (req.start) begin
      q_nxt = req.dividend; rem_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = 5'd16; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = q_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("divider done while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r |-> cnt_r != 5'd0)) else $error("divider count ran out");
endmodule
`default_nettype wire

/* test/gamepad_pose_commander_core_tb.sv */
// ----------------------------------------------------------------------------
// gamepad_pose_commander_core_tb: self-checking bench for the pose commander
// Drives gamepad reports and register writes, predicts every posture and
// movement command in the bench, and compares each output transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none
module gamepad_pose_commander_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpc_pkg::*;

  typedef struct {
    pose_t       kind;
    logic [9:0]  x;
    logic [10:0] y;
    logic [12:0] z;
    logic [15:0] ms;
    logic [4:0]  speed;
    logic        last;
  } command_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [15:0] in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  gamepad_pose_commander_core u_dut (.*);

  // Bench copy of the block's registers and state.
  logic [14:0] dz_level;
  logic [4:0]  spd_floor, spd_ceil, spd;
  logic [11:0] base_ms;
  logic        motion_en, servo_en;
  logic [7:0]  held;

  command_t expected_cmds[$];
  int       error_count;
  int       hold_off;
  bit       drain_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("gamepad_pose_commander_core_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int signed axis_value(input logic [15:0] raw);
    int signed s;
    int        mag;
    s = $signed(raw);
    mag = s < 0 ? -s : s;
    if (mag < dz_level) return 0;
    return s;
  endfunction

  function automatic int signed scaled(input int signed q, input int k);
    int mag, r;
    mag = q < 0 ? -q : q;
    r = (mag * k + (1 << 14)) >> 15;
    return q < 0 ? -r : r;
  endfunction

  function automatic int signed clip(input int signed v, input int signed lo,
                                     input int signed hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic command_t make_cmd(input pose_t k, input int signed x,
                                        input int signed y, input int signed z,
                                        input int ms);
    command_t c;
    c.kind = k; c.x = x[9:0]; c.y = y[10:0]; c.z = z[12:0]; c.ms = ms[15:0];
    c.speed = spd; c.last = 1'b0;
    return c;
  endfunction

  // Works out the commands one report causes and queues them.
  task automatic predict_commands(input logic [63:0] d, input logic [15:0] u);
    command_t cmds[$];
    int signed lx, ly, rx, ry, x, y, z;
    int        fl, cl, ms;
    logic [13:0] btn;
    bit        down;
    int        bidx[8] = '{0, 1, 2, 3, 4, 8, 9, 10};
    if (!u[0]) return;
    lx = axis_value(d[15:0]);  ly = axis_value(d[31:16]);
    rx = axis_value(d[47:32]); ry = axis_value(d[63:48]);
    btn = u[14:1];
    fl = spd_floor == 0 ? 1 : spd_floor;
    cl = spd_ceil == 0 ? 1 : spd_ceil;
    for (int i = 0; i < 8; i++) begin
      down = btn[bidx[i]];
      if (down && !held[i]) begin
        case (i)
          0: spd = (int'(spd) - 1 > fl) ? spd - 5'd1 : fl[4:0];
          1: spd = (int'(spd) + 1 < cl) ? spd + 5'd1 : cl[4:0];
          2: cmds.push_back(make_cmd(POSE_SIT, 0, NEUTRAL_Y, SIT_Z, POSTURE_MS));
          3: cmds.push_back(make_cmd(POSE_STAND, 0, NEUTRAL_Y, STAND_Z, POSTURE_MS));
          4: begin
            servo_en = !servo_en;
            if (servo_en)
              cmds.push_back(make_cmd(POSE_STAND, 0, NEUTRAL_Y, STAND_Z, POSTURE_MS));
          end
          5: motion_en = 1'b0;
          6: motion_en = 1'b1;
          default: spd = SPEED_UNITY;
        endcase
      end
      held[i] = down;
    end
    if (motion_en && servo_en && (lx != 0 || ly != 0 || rx != 0 || ry != 0)) begin
      x = clip(scaled(ly, 300), -500, 500);
      y = clip(1000 + scaled(lx, 200), 500, 1500);
      z = clip(-2000 + scaled(ry, 300), -2500, -1200);
      ms = (int'(base_ms) * 10) / (spd == 0 ? 1 : int'(spd));
      if (ms < 50) ms = 50;
      cmds.push_back(make_cmd(POSE_MOVE, x, y, z, ms));
    end
    if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
    foreach (cmds[i]) expected_cmds.push_back(cmds[i]);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_report(input logic [63:0] d, input logic [15:0] u,
                             input bit no_gaps = 0);
    int g;
    g = no_gaps ? 0 : gap_len();
    repeat (g) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= u;
    do @(posedge clk); while (!in_tready);
    predict_commands(d, u);
    in_tvalid <= 1'b0;
    // The block is busy after a transfer and takes no report until idle, so
    // dropping valid here costs nothing and keeps it from being driven twice.
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_cmds.size() > 0) @(posedge clk);
    // Reports that cause no command may still be in progress.
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DEADZONE: dz_level  = val;
      CFG_FLOOR:    spd_floor = val[4:0];
      CFG_CEILING:  spd_ceil  = val[4:0];
      default:      base_ms   = val[11:0];
    endcase
    @(posedge clk);
  endtask

  function automatic logic [63:0] sticks(input int a, input int b, input int c,
                                         input int e);
    return {e[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  function automatic logic [15:0] pad(input logic [13:0] btn, input bit ok = 1);
    return {1'b0, btn, ok};
  endfunction

  function automatic logic [15:0] rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r < 4)
      return 16'(int'($urandom_range(0, 6000)) * ($urandom_range(0, 1) ? 1 : -1));
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_report(sticks(0, 0, 0, 0), pad(0));
    send_report(sticks(32767, -32767, 32767, 32767), pad(0));
    send_report(sticks(-32768, -32768, -32768, -32768), pad(0));
    send_report(sticks(0, 0, 32767, 0), pad(0));       // rotation alone still moves
    send_report(sticks(4914, -4914, 0, 0), pad(0));    // just inside dead zone
    send_report(sticks(4915, -4915, 0, 4915), pad(0));
    send_report(sticks(20000, 20000, 0, 0), pad(14'h3FFF, 0)); // dropped
    send_report(sticks(20000, 0, 0, 0), pad(14'h0004)); // sit
    send_report(sticks(20000, 0, 0, 0), pad(14'h000C)); // stand, sit held
    send_report(sticks(20000, 0, 0, 0), pad(14'h0010)); // servo off
    send_report(sticks(20000, 0, 0, 0), pad(0));
    send_report(sticks(20000, 0, 0, 0), pad(14'h001C)); // servo on, sit, stand
    send_report(sticks(20000, 0, 0, 0), pad(14'h0100)); // stop
    send_report(sticks(20000, 0, 0, 0), pad(14'h0200)); // go
    for (int i = 0; i < 12; i++)
      send_report(sticks(0, 9000, 0, 0), pad(i[0] ? 14'h0001 : 14'h0000));
    send_report(sticks(0, 9000, 0, 0), pad(14'h0400)); // speed reset
    for (int i = 0; i < 6; i++)
      send_report(sticks(0, 9000, 0, 0), pad(i[0] ? 14'h0002 : 14'h0000));
    send_report(sticks(0, 9000, 0, 0), pad(14'h3FFF));
    send_report(sticks(0, 9000, 0, 0), pad(14'h3800)); // unused bits only
  endtask

  task automatic test_random(input int count);
    logic [13:0] btn;
    for (int i = 0; i < count; i++) begin
      btn = $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'(1 << $urandom_range(0, 10));
      if ($urandom_range(0, 2) == 0) btn = '0;
      send_report({rand_axis(), rand_axis(), rand_axis(), rand_axis()},
                  pad(btn, $urandom_range(0, 9) != 0));
    end
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_DEADZONE, 15'd0);
    write_reg(CFG_FLOOR, 15'd0);
    write_reg(CFG_CEILING, 15'd0);
    write_reg(CFG_BASE, 15'd50);
    test_random(40);
    wait_drained();
    write_reg(CFG_DEADZONE, 15'd32767);
    write_reg(CFG_FLOOR, 15'd20);
    write_reg(CFG_CEILING, 15'd1);   // crossed bounds
    write_reg(CFG_BASE, 15'd4000);
    test_random(40);
    wait_drained();
    write_reg(CFG_DEADZONE, 15'($urandom_range(0, 12000)));
    write_reg(CFG_FLOOR, 15'($urandom_range(1, 8)));
    write_reg(CFG_CEILING, 15'($urandom_range(12, 31)));
    write_reg(CFG_BASE, 15'h7FFF);   // high bits are dropped
    test_random(60);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 20; i++)
      send_report(sticks(12000, -12000, 0, 12000), pad(i[0] ? 14'h000C : 14'h0), 1);
    wait_drained();
  endtask

  // Sink side: short random stalls, an occasional long one, and a long
  // counted hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (drain_quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 199) == 0) hold_off <= $urandom_range(8, 40);
    end
  end

  always @(posedge clk) begin
    command_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected command", 32'(out_tuser), 32'd0);
      end else begin
        e = expected_cmds.pop_front();
        if (out_tuser != e.kind)
          report_mismatch("pose_kind", 32'(out_tuser), 32'(e.kind));
        if (out_tdata[9:0] != e.x)
          report_mismatch("foot_x", 32'(out_tdata[9:0]), 32'(e.x));
        if (out_tdata[20:10] != e.y)
          report_mismatch("foot_y", 32'(out_tdata[20:10]), 32'(e.y));
        if (out_tdata[33:21] != e.z)
          report_mismatch("foot_z", 32'(out_tdata[33:21]), 32'(e.z));
        if (out_tdata[49:34] != e.ms)
          report_mismatch("move_ms", 32'(out_tdata[49:34]), 32'(e.ms));
        if (out_tdata[54:50] != e.speed)
          report_mismatch("speed_now", 32'(out_tdata[54:50]), 32'(e.speed));
        if (out_tdata[55] != 1'b0)
          report_mismatch("pad bit", 32'(out_tdata[55]), 32'd0);
        if (out_tlast != e.last)
          report_mismatch("last_of_run", 32'(out_tlast), 32'(e.last));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_valid = 1'b0; cfg_index = CFG_DEADZONE; cfg_data = '0;
    hold_off = 0; drain_quiet = 0; error_count = 0;
    dz_level = 15'd4915; spd_floor = 5'd1; spd_ceil = 5'd20; base_ms = 12'd1000;
    spd = SPEED_UNITY; motion_en = 1'b1; servo_en = 1'b1; held = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    wait_drained();
    test_random(80);
    test_backpressure();
    test_config_sweep();
    write_reg(CFG_DEADZONE, 15'd4915);
    write_reg(CFG_FLOOR, 15'd1);
    write_reg(CFG_CEILING, 15'd20);
    write_reg(CFG_BASE, 15'd1000);
    test_random(100);
    drain_quiet = 1;
    wait_drained();
    if (error_count == 0) begin
      $display("gamepad_pose_commander_core_tb: done, clean");
    end else begin
      $display("gamepad_pose_commander_core_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
